/* rtl/core/tile_map_background_pixel_defines.svh */
// ----------------------------------------------------------------------------
// tile map background pixel: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_BACKGROUND_PIXEL_DEFINES_SVH
`define TILE_MAP_BACKGROUND_PIXEL_DEFINES_SVH

// same-cycle implication, held off during reset
`define TMBP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define TMBP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/tmbp_pkg.sv */
// ----------------------------------------------------------------------------
// tmbp_pkg
// Types and codes shared by the tile map background pixel block.
// ----------------------------------------------------------------------------
package tmbp_pkg;

  // default memory sizes
  localparam int DEF_VIDEO_WORDS     = 32768;
  localparam int DEF_PALETTE_ENTRIES = 256;

  // item kinds
  localparam logic [1:0] KIND_VIDEO   = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_RENDER  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_BG_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_MAP_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_MAP_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_SCROLL_H   = 3'd3;
  localparam logic [2:0] CFG_SCROLL_V   = 3'd4;

  // map size selects
  localparam logic [1:0] MAP_W32 = 2'd0;
  localparam logic [1:0] MAP_W64 = 2'd1;
  localparam logic       MAP_H32 = 1'b0;

  typedef struct packed {
    logic       bg_enable;
    logic [1:0] map_width_sel;
    logic       map_height_sel;
    logic [9:0] scroll_horiz;
    logic [8:0] scroll_vert;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_PAT_A,
    ST_PAT_B,
    ST_PAL
  } fetch_state_t;

endpackage

/* rtl/core/tmbp_ram.sv */
// ----------------------------------------------------------------------------
// tmbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/tmbp_fetch.sv */
// ----------------------------------------------------------------------------
// tmbp_fetch
// Pixel sequencer: map word, two pattern words (layer on) and palette byte are
// read in turn from the video and palette RAMs; write items go straight to them.
// ----------------------------------------------------------------------------
module tmbp_fetch #(
  parameter int VIDEO_WORDS     = 32768,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  tmbp_pkg::cfg_t cfg,
  input  logic           start,
  input  logic [1:0]     kind,
  input  logic [14:0]    address,
  input  logic [15:0]    data,
  input  logic [8:0]     pixel_x,
  input  logic [7:0]     line,
  output logic           busy,
  output logic           done,
  output logic [7:0]     color,
  output logic           opaque
);

  import tmbp_pkg::*;

  localparam int VAW = $clog2(VIDEO_WORDS);
  localparam int PAW = $clog2(PALETTE_ENTRIES);

  fetch_state_t state, state_next;

  logic           accept;
  logic [9:0]     px_sum;
  logic [8:0]     py_sum;
  logic [6:0]     tx;
  logic [5:0]     ty;
  logic [2:0]     row_shift;
  logic [12:0]    map_addr;
  logic [14:0]    vram_rd15;
  logic [VAW-1:0] vram_raddr;
  logic [15:0]    vram_rdata;
  logic           vram_we;
  logic [PAW-1:0] pal_raddr;
  logic           pal_we;
  logic [2:0]     bit_sel;
  logic [3:0]     color_idx;
  logic [7:0]     pal_idx;

  // per-item registers
  logic [2:0]  fine_x;
  logic [2:0]  fine_y;
  logic [10:0] tile;
  logic [3:0]  block;
  logic [15:0] word_a;

  assign accept = start && (state == ST_IDLE);

  // scrolled position; only the bits the widest map uses are kept
  assign px_sum = 10'(pixel_x) + cfg.scroll_horiz;
  assign py_sum = 9'(line) + cfg.scroll_vert;

  // wrap tile coordinates by the map size
  always_comb begin
    case (cfg.map_width_sel)
      MAP_W32: begin
        tx        = {2'b00, px_sum[7:3]};
        row_shift = 3'd5;
      end
      MAP_W64: begin
        tx        = {1'b0, px_sum[8:3]};
        row_shift = 3'd6;
      end
      default: begin
        tx        = px_sum[9:3];
        row_shift = 3'd7;
      end
    endcase
    if (cfg.map_height_sel == MAP_H32) begin
      ty = {1'b0, py_sum[7:3]};
    end else begin
      ty = py_sum[8:3];
    end
  end

  // tx stays below the row width, so or-ing the row offset is an add
  assign map_addr = 13'(tx) | (13'(ty) << row_shift);

  // video read address per step
  always_comb begin
    case (state)
      ST_IDLE:  vram_rd15 = {2'b00, map_addr};
      ST_MAP:   vram_rd15 = {vram_rdata[10:0], 1'b0, fine_y};
      ST_PAT_A: vram_rd15 = {tile, 1'b1, fine_y};
      default:  vram_rd15 = '0;
    endcase
  end

  assign vram_raddr = VAW'(vram_rd15);
  assign vram_we    = accept && (kind == KIND_VIDEO);
  assign pal_we     = accept && (kind == KIND_PALETTE);

  // color index, leftmost pixel in the msb of each plane
  assign bit_sel   = ~fine_x;
  assign color_idx = {vram_rdata[{1'b1, bit_sel}], vram_rdata[{1'b0, bit_sel}],
                      word_a[{1'b1, bit_sel}], word_a[{1'b0, bit_sel}]};
  assign pal_idx   = (color_idx == 4'd0) ? 8'h00 : {block, color_idx};
  assign pal_raddr = (state == ST_PAT_B) ? PAW'(pal_idx) : '0;

  tmbp_ram #(
    .WIDTH (16),
    .DEPTH (VIDEO_WORDS)
  ) u_vram (
    .clk     (clk),
    .wr_en   (vram_we),
    .wr_addr (VAW'(address)),
    .wr_data (data),
    .rd_addr (vram_raddr),
    .rd_data (vram_rdata)
  );

  tmbp_ram #(
    .WIDTH (8),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_we),
    .wr_addr (PAW'(address)),
    .wr_data (data[7:0]),
    .rd_addr (pal_raddr),
    .rd_data (color)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    busy       = (state != ST_IDLE);
    done       = (state == ST_PAL);
    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_RENDER)) begin
          state_next = cfg.bg_enable ? ST_MAP : ST_PAL;
        end
      end
      ST_MAP:   state_next = ST_PAT_A;
      ST_PAT_A: state_next = ST_PAT_B;
      ST_PAT_B: state_next = ST_PAL;
      ST_PAL:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // per-item payload capture
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        fine_x <= px_sum[2:0];
        fine_y <= py_sum[2:0];
        opaque <= 1'b0;
      end
      ST_MAP: begin
        tile  <= vram_rdata[10:0];
        block <= vram_rdata[15:12];
      end
      ST_PAT_A: word_a <= vram_rdata;
      ST_PAT_B: opaque <= (color_idx != 4'd0);
      default: ;
    endcase
  end

endmodule

/* rtl/core/tile_map_background_pixel.sv */
// ----------------------------------------------------------------------------
// tile_map_background_pixel
// Background layer of a tile video chip: video and palette RAM writes, and
// one background pixel per render item.
// ----------------------------------------------------------------------------
// Render item (taken in idle), layer on: ST_MAP, ST_PAT_A, ST_PAT_B, ST_PAL,
//   busy throughout, result strobe (done) in ST_PAL; set by three dependent
//   video RAM reads plus the palette read. Layer off: straight to ST_PAL.
// Write items: taken in idle, busy stays low. The receiver cannot stall.
// Reset: configuration returns to its defaults and the sequencer to idle;
//   RAM contents are not cleared (no clearing pass).
module tile_map_background_pixel #(
  parameter int VIDEO_WORDS     = tmbp_pkg::DEF_VIDEO_WORDS,
  parameter int PALETTE_ENTRIES = tmbp_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [14:0] address,
  input  logic [15:0] data,
  input  logic [8:0]  pixel_x,
  input  logic [7:0]  line,
  output logic        busy,
  output logic        done,
  output logic [7:0]  color,
  output logic        opaque
);

  import tmbp_pkg::*;

`include "tile_map_background_pixel_defines.svh"

  cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bg_enable      <= 1'b1;
      cfg.map_width_sel  <= MAP_W32;
      cfg.map_height_sel <= MAP_H32;
      cfg.scroll_horiz   <= '0;
      cfg.scroll_vert    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BG_ENABLE:  cfg.bg_enable      <= cfg_data[0];
        CFG_MAP_WIDTH:  cfg.map_width_sel  <= cfg_data[1:0];
        CFG_MAP_HEIGHT: cfg.map_height_sel <= cfg_data[0];
        CFG_SCROLL_H:   cfg.scroll_horiz   <= cfg_data;
        CFG_SCROLL_V:   cfg.scroll_vert    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  tmbp_fetch #(
    .VIDEO_WORDS     (VIDEO_WORDS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_fetch (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .start   (start),
    .kind    (kind),
    .address (address),
    .data    (data),
    .pixel_x (pixel_x),
    .line    (line),
    .busy    (busy),
    .done    (done),
    .color   (color),
    .opaque  (opaque)
  );

  // sequencer checks
  `TMBP_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a render item")
  `TMBP_ASSERT_NEXT(a_done_idle, done, !busy, "sequencer not idle after result")
  `TMBP_ASSERT_NEXT(a_render_busy, start && !busy && kind == KIND_RENDER, busy,
    "render item did not start the sequencer")
  `TMBP_ASSERT_NEXT(a_write_quiet, start && !busy && kind != KIND_RENDER,
    !busy && !done, "write item started the sequencer")

endmodule
